// ===== rtl/direct_form_iir_filter_top_assert.svh =====
// ---------------------------------------------------------------------------
// direct_form_iir_filter_top assertion macros
// concurrent checks used at the end of the top level
// ---------------------------------------------------------------------------
`ifndef DIRECT_FORM_IIR_FILTER_TOP_ASSERT_SVH
`define DIRECT_FORM_IIR_FILTER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define DFIIR_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define DFIIR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dfiir_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfiir_pkg
// shared constants, codes and types of the direct form I iir filter
// ---------------------------------------------------------------------------
package dfiir_pkg;

	localparam int MAX_TAP_COUNT = 16;
	localparam int TAP_W         = $clog2(MAX_TAP_COUNT);
	localparam int STEP_W        = TAP_W + 1;
	localparam int TAP_IDX_W     = 4;
	localparam int COEF_W        = 32;
	localparam int SAMPLE_W      = 24;
	localparam int TAPS_W        = 5;
	localparam int OP_W          = 2;
	localparam int CFG_IDX_W     = 1;
	localparam int PROD_W        = COEF_W + SAMPLE_W;
	localparam int ACC_W         = PROD_W + TAP_W + 2;
	localparam int FRAC_SHIFT    = 28;

	localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_NUM = 2'd1;
	localparam logic [OP_W-1:0] OP_WR_DEN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DEN_TAPS = 1'b1;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

	typedef struct packed {
		logic signed [COEF_W-1:0]   b;
		logic signed [COEF_W-1:0]   a;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
	} cell_t;

	typedef struct packed {
		logic rotate;
		logic hist_shift;
		logic num_wr;
		logic den_wr;
		logic y_set;
	} cell_ctrl_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic sub;
		logic use_term;
	} mac_ctrl_t;

endpackage

// ===== rtl/dfiir_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfiir_cell
// one tap slot: coefficient pair and history pair, rotates with its neighbor
// ---------------------------------------------------------------------------
module dfiir_cell (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    head,
	input  dfiir_pkg::cell_ctrl_t                   ctrl,
	input  logic signed [dfiir_pkg::COEF_W-1:0]     coef,
	input  logic signed [dfiir_pkg::SAMPLE_W-1:0]   y_value,
	input  dfiir_pkg::cell_t                        rot_in,
	input  dfiir_pkg::cell_t                        hist_in,
	output dfiir_pkg::cell_t                        data
);

	dfiir_pkg::cell_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q.b <= head ? dfiir_pkg::COEF_ONE : '0;
			data_q.a <= head ? dfiir_pkg::COEF_ONE : '0;
			data_q.x <= '0;
			data_q.y <= '0;
		end else if (ctrl.rotate) begin
			data_q <= rot_in;
		end else begin
			if (ctrl.hist_shift) begin
				data_q.x <= hist_in.x;
				data_q.y <= hist_in.y;
			end
			if (ctrl.y_set) begin
				data_q.y <= y_value;
			end
			if (ctrl.num_wr) begin
				data_q.b <= coef;
			end
			if (ctrl.den_wr) begin
				data_q.a <= coef;
			end
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/dfiir_mac.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfiir_mac
// shared multiply-accumulate with rounding and saturation to sample range
// ---------------------------------------------------------------------------
module dfiir_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dfiir_pkg::mac_ctrl_t                    ctrl,
	input  logic signed [dfiir_pkg::COEF_W-1:0]     coef,
	input  logic signed [dfiir_pkg::SAMPLE_W-1:0]   smp,
	output logic signed [dfiir_pkg::SAMPLE_W-1:0]   result,
	output logic                                    sat
);

	localparam int Q_W = dfiir_pkg::ACC_W - dfiir_pkg::FRAC_SHIFT;
	localparam logic signed [dfiir_pkg::ACC_W-1:0] HALF =
		dfiir_pkg::ACC_W'(1) <<< (dfiir_pkg::FRAC_SHIFT - 1);
	localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((2 ** (dfiir_pkg::SAMPLE_W - 1)) - 1);
	localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(2 ** (dfiir_pkg::SAMPLE_W - 1));

	logic signed [dfiir_pkg::PROD_W-1:0] prod_s1;
	logic                                sub_s1;
	logic                                v_s1;
	logic signed [dfiir_pkg::ACC_W-1:0]  acc_q;
	logic signed [dfiir_pkg::ACC_W-1:0]  prod_ext;
	logic signed [dfiir_pkg::ACC_W-1:0]  rnd;
	logic signed [Q_W-1:0]               q;

	always_ff @(posedge clk) begin
		prod_s1 <= ctrl.use_term ?
			dfiir_pkg::PROD_W'(coef) * dfiir_pkg::PROD_W'(smp) : '0;
		sub_s1  <= ctrl.sub;
	end

	assign prod_ext = dfiir_pkg::ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			acc_q <= '0;
		end else if (ctrl.clear) begin
			v_s1  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctrl.step;
			if (v_s1) begin
				acc_q <= sub_s1 ? acc_q - prod_ext : acc_q + prod_ext;
			end
		end
	end

	// round half up, then clip
	assign rnd = acc_q + HALF;
	assign q   = rnd[dfiir_pkg::ACC_W-1:dfiir_pkg::FRAC_SHIFT];

	always_comb begin
		sat    = 1'b0;
		result = q[dfiir_pkg::SAMPLE_W-1:0];
		if (q > SAT_HI) begin
			sat    = 1'b1;
			result = SAT_HI[dfiir_pkg::SAMPLE_W-1:0];
		end else if (q < SAT_LO) begin
			sat    = 1'b1;
			result = SAT_LO[dfiir_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

// ===== rtl/direct_form_iir_filter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// direct_form_iir_filter_top
// direct form I iir filter over a rotating row of tap cells
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | operation, tap_index, coefficient_value, sample_in
//  out     | out_valid / out_stall| sample_out, saturated
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// in a filter transfer the cell row rotates once past the single multiplier,
// two products per cell. coefficient writes give no output.
// reset loads unity leading coefficients and clears both histories at once.
// input stalls while a sample is in work; a full output register holds the
// finished sample until out_stall drops, the next sample may already enter.
// ---------------------------------------------------------------------------
module direct_form_iir_filter_top (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [dfiir_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [dfiir_pkg::TAPS_W-1:0]              cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [dfiir_pkg::OP_W-1:0]                operation,
	input  logic [dfiir_pkg::TAP_IDX_W-1:0]           tap_index,
	input  logic signed [dfiir_pkg::COEF_W-1:0]       coefficient_value,
	input  logic signed [dfiir_pkg::SAMPLE_W-1:0]     sample_in,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [dfiir_pkg::SAMPLE_W-1:0]     sample_out,
	output logic                                      saturated
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;
	localparam logic [dfiir_pkg::STEP_W-1:0] LAST_STEP =
		dfiir_pkg::STEP_W'(2 * dfiir_pkg::MAX_TAP_COUNT - 1);

	logic [1:0]                              state_q;
	logic [dfiir_pkg::STEP_W-1:0]            cnt_q;
	logic [dfiir_pkg::TAPS_W-1:0]            num_taps_q;
	logic [dfiir_pkg::TAPS_W-1:0]            den_taps_q;
	logic                                    out_valid_q;
	logic signed [dfiir_pkg::SAMPLE_W-1:0]   sample_out_q;
	logic                                    saturated_q;

	logic                                    in_xfer;
	logic                                    filt_go;
	logic                                    load_out;
	logic                                    phase;
	logic [dfiir_pkg::TAP_W-1:0]             tap;
	logic                                    rotate;
	dfiir_pkg::mac_ctrl_t                    mac_ctrl;
	logic signed [dfiir_pkg::COEF_W-1:0]     mac_coef;
	logic signed [dfiir_pkg::SAMPLE_W-1:0]   mac_smp;
	logic signed [dfiir_pkg::SAMPLE_W-1:0]   mac_result;
	logic                                    mac_sat;
	dfiir_pkg::cell_t                        cells [dfiir_pkg::MAX_TAP_COUNT];
	dfiir_pkg::cell_t                        head_in;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign filt_go  = in_xfer && (operation == dfiir_pkg::OP_FILTER);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign phase  = cnt_q[0];
	assign tap    = cnt_q[dfiir_pkg::STEP_W-1:1];
	assign rotate = (state_q == ST_RUN) && phase;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= dfiir_pkg::TAPS_W'(1);
			den_taps_q <= dfiir_pkg::TAPS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				dfiir_pkg::REG_NUM_TAPS: num_taps_q <= cfg_data;
				dfiir_pkg::REG_DEN_TAPS: den_taps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (filt_go) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + dfiir_pkg::STEP_W'(1);
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_out_q <= mac_result;
			saturated_q  <= mac_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;

	// shared mac fed from the head cell
	always_comb begin
		mac_ctrl.clear = filt_go;
		mac_ctrl.step  = (state_q == ST_RUN);
		mac_ctrl.sub   = phase;
		if (phase) begin
			mac_ctrl.use_term = (tap != '0) && (int'(tap) < int'(den_taps_q));
		end else begin
			mac_ctrl.use_term = (tap == '0) || (int'(tap) < int'(num_taps_q));
		end
		mac_coef = phase ? cells[0].a : cells[0].b;
		mac_smp  = phase ? cells[0].y : cells[0].x;
	end

	dfiir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   (mac_coef),
		.smp    (mac_smp),
		.result (mac_result),
		.sat    (mac_sat)
	);

	// new sample enters the head of the history row
	always_comb begin
		head_in   = '0;
		head_in.x = sample_in;
	end

	for (genvar j = 0; j < dfiir_pkg::MAX_TAP_COUNT; j++) begin : g_cell
		dfiir_pkg::cell_ctrl_t cell_ctrl;
		dfiir_pkg::cell_t      hist_src;

		always_comb begin
			cell_ctrl.rotate     = rotate;
			cell_ctrl.hist_shift = filt_go;
			cell_ctrl.num_wr     = in_xfer && (operation == dfiir_pkg::OP_WR_NUM) &&
				(int'(tap_index) == j);
			cell_ctrl.den_wr     = in_xfer && (operation == dfiir_pkg::OP_WR_DEN) &&
				(int'(tap_index) == j);
			cell_ctrl.y_set      = load_out && (j == 0);
		end

		if (j == 0) begin : g_head
			assign hist_src = head_in;
		end else begin : g_body
			assign hist_src = cells[j-1];
		end

		dfiir_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.head    (j == 0),
			.ctrl    (cell_ctrl),
			.coef    (coefficient_value),
			.y_value (mac_result),
			.rot_in  (cells[(j + 1) % dfiir_pkg::MAX_TAP_COUNT]),
			.hist_in (hist_src),
			.data    (cells[j])
		);
	end

	`include "direct_form_iir_filter_top_assert.svh"

	`DFIIR_ASSERT_NEXT(a_filter_starts, clk, arst_n, filt_go, state_q == ST_RUN && cnt_q == '0, "filter transfer did not start the tap pass")
	`DFIIR_ASSERT_NEXT(a_feedback_written, clk, arst_n, load_out, out_valid_q && cells[0].y == sample_out_q, "output history not in step with output register")
	`DFIIR_ASSERT_SAME(a_idle_count, clk, arst_n, state_q == ST_IDLE, cnt_q == '0, "step count left nonzero outside a tap pass")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for the direct form I IIR filter. A short directed table covers
// the sample extremes, coefficient extremes, rounding and the ignored
// operation. Random phases follow: tap counts set while the block is idle,
// full coefficient loads, then sample streams mixed with noise items. Every
// output transfer is checked against the table or a fixed point filter model.
// ---------------------------------------------------------------------------
module tb;

	localparam logic [dfiir_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int NUM_PHASES     = 16;
	localparam int PHASE_SAMPLES  = 70;
	localparam int DRAIN_CYCLES   = 2 * dfiir_pkg::MAX_TAP_COUNT + 8;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DIRECTED_ROWS  = 25;
	localparam int SAMPLE_HI      = 8388607;
	localparam int SAMPLE_LO      = -8388608;

	typedef struct {
		logic [dfiir_pkg::OP_W-1:0]            op;
		logic [dfiir_pkg::TAP_IDX_W-1:0]       idx;
		logic signed [dfiir_pkg::COEF_W-1:0]   coef;
		logic signed [dfiir_pkg::SAMPLE_W-1:0] smp;
		bit                                    known;
		logic signed [dfiir_pkg::SAMPLE_W-1:0] y;
		logic                                  clip;
	} directed_row_t;

	typedef struct {
		logic signed [dfiir_pkg::SAMPLE_W-1:0] sample;
		logic                                  clip;
	} filtered_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  cfg_we;
	logic [dfiir_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [dfiir_pkg::TAPS_W-1:0]          cfg_data;
	logic                                  in_valid;
	logic                                  in_stall;
	logic [dfiir_pkg::OP_W-1:0]            operation;
	logic [dfiir_pkg::TAP_IDX_W-1:0]       tap_index;
	logic signed [dfiir_pkg::COEF_W-1:0]   coefficient_value;
	logic signed [dfiir_pkg::SAMPLE_W-1:0] sample_in;
	logic                                  out_valid;
	logic                                  out_stall;
	logic signed [dfiir_pkg::SAMPLE_W-1:0] sample_out;
	logic                                  saturated;

	// filter model state
	logic signed [dfiir_pkg::COEF_W-1:0]   num_coef [dfiir_pkg::MAX_TAP_COUNT];
	logic signed [dfiir_pkg::COEF_W-1:0]   den_coef [dfiir_pkg::MAX_TAP_COUNT];
	logic signed [dfiir_pkg::SAMPLE_W-1:0] x_hist [dfiir_pkg::MAX_TAP_COUNT];
	logic signed [dfiir_pkg::SAMPLE_W-1:0] y_hist [dfiir_pkg::MAX_TAP_COUNT];
	logic [dfiir_pkg::TAP_W-1:0]           ring_pos;
	logic [dfiir_pkg::TAPS_W-1:0]          num_taps;
	logic [dfiir_pkg::TAPS_W-1:0]          den_taps;

	filtered_t expected_outputs[$];
	filtered_t oldest;
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	int        in_gap_pct;
	int        out_stall_pct;
	bit        hold_request;
	bit        hold_done;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh000000, 1'b1, 24'sh000000, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh7FFFFF, 1'b1, 24'sh7FFFFF, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh800000, 1'b1, 24'sh800000, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh000001, 1'b1, 24'sh000001, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'shFFFFFF, 1'b1, 24'shFFFFFF, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh555555, 1'b1, 24'sh555555, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'shAAAAAA, 1'b1, 24'shAAAAAA, 1'b0},
		'{OP_UNUSED, 4'hF, 32'shFFFF_FFFF, 24'shFFFFFF, 1'b0, 24'sh0, 1'b0},
		'{dfiir_pkg::OP_WR_NUM, 4'd0, 32'sh7FFF_FFFF, 24'sh0, 1'b0, 24'sh0, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh7FFFFF, 1'b1, 24'sh7FFFFF, 1'b1},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh800000, 1'b1, 24'sh800000, 1'b1},
		'{dfiir_pkg::OP_WR_NUM, 4'd0, 32'sh8000_0000, 24'sh0, 1'b0, 24'sh0, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh7FFFFF, 1'b1, 24'sh800000, 1'b1},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh800000, 1'b1, 24'sh7FFFFF, 1'b1},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh000000, 1'b1, 24'sh000000, 1'b0},
		'{dfiir_pkg::OP_WR_NUM, 4'd0, 32'sh0800_0000, 24'sh0, 1'b0, 24'sh0, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh000001, 1'b1, 24'sh000001, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'shFFFFFF, 1'b1, 24'sh000000, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh000003, 1'b1, 24'sh000002, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'shFFFFFD, 1'b1, 24'shFFFFFF, 1'b0},
		'{dfiir_pkg::OP_WR_DEN, 4'd0, 32'sh1234_5678, 24'sh0, 1'b0, 24'sh0, 1'b0},
		'{dfiir_pkg::OP_WR_NUM, 4'hF, 32'shFFFF_FFFF, 24'sh0, 1'b0, 24'sh0, 1'b0},
		'{dfiir_pkg::OP_WR_DEN, 4'hF, 32'sh7FFF_FFFF, 24'sh0, 1'b0, 24'sh0, 1'b0},
		'{dfiir_pkg::OP_WR_NUM, 4'd0, dfiir_pkg::COEF_ONE, 24'sh0, 1'b0, 24'sh0, 1'b0},
		'{dfiir_pkg::OP_FILTER, 4'd0, 32'sd0, 24'sh123456, 1'b0, 24'sh0, 1'b0}
	};

	direct_form_iir_filter_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.tap_index         (tap_index),
		.coefficient_value (coefficient_value),
		.sample_in         (sample_in),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.sample_out        (sample_out),
		.saturated         (saturated)
	);

	always #1 clk = ~clk;

	function automatic void compute_iir_output(
		input  logic [dfiir_pkg::OP_W-1:0]            op,
		input  logic [dfiir_pkg::TAP_IDX_W-1:0]       idx,
		input  logic signed [dfiir_pkg::COEF_W-1:0]   coef,
		input  logic signed [dfiir_pkg::SAMPLE_W-1:0] x,
		output bit                                    produced,
		output logic signed [dfiir_pkg::SAMPLE_W-1:0] y,
		output logic                                  clip
	);
		longint                      acc;
		longint                      r;
		int                          nn;
		int                          nd;
		logic [dfiir_pkg::TAP_W-1:0] slot;
		produced = 1'b0;
		y = '0;
		clip = 1'b0;
		case (op)
			dfiir_pkg::OP_WR_NUM: num_coef[idx] = coef;
			dfiir_pkg::OP_WR_DEN: den_coef[idx] = coef;
			dfiir_pkg::OP_FILTER: begin
				nn = (num_taps == 0) ? 1 : ((num_taps > dfiir_pkg::MAX_TAP_COUNT) ?
					dfiir_pkg::MAX_TAP_COUNT : int'(num_taps));
				nd = (den_taps == 0) ? 1 : ((den_taps > dfiir_pkg::MAX_TAP_COUNT) ?
					dfiir_pkg::MAX_TAP_COUNT : int'(den_taps));
				acc = longint'(num_coef[0]) * longint'(x);
				for (int k = 1; k < nn; k++) begin
					slot = dfiir_pkg::TAP_W'(int'(ring_pos) + k - 1);
					acc += longint'(num_coef[k]) * longint'(x_hist[slot]);
				end
				// leading denominator coefficient is taken as one, its written value is unused
				for (int k = 1; k < nd; k++) begin
					slot = dfiir_pkg::TAP_W'(int'(ring_pos) + k - 1);
					acc -= longint'(den_coef[k]) * longint'(y_hist[slot]);
				end
				r = (acc + (longint'(1) << (dfiir_pkg::FRAC_SHIFT - 1))) >>>
					dfiir_pkg::FRAC_SHIFT;
				if (r > SAMPLE_HI) begin
					r = SAMPLE_HI;
					clip = 1'b1;
				end else if (r < SAMPLE_LO) begin
					r = SAMPLE_LO;
					clip = 1'b1;
				end
				ring_pos = ring_pos - 1'b1;
				x_hist[ring_pos] = x;
				y_hist[ring_pos] = r[dfiir_pkg::SAMPLE_W-1:0];
				y = r[dfiir_pkg::SAMPLE_W-1:0];
				produced = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [dfiir_pkg::COEF_W-1:0] random_coef(input int span);
		int v;
		case ($urandom_range(0, 15))
			0: v = $urandom;
			1: v = 0;
			2: v = dfiir_pkg::COEF_ONE;
			default: v = int'($urandom_range(0, (1 << (span + 1)) - 1)) - (1 << span);
		endcase
		return v;
	endfunction

	function automatic logic signed [dfiir_pkg::SAMPLE_W-1:0] random_sample();
		logic signed [dfiir_pkg::SAMPLE_W-1:0] s;
		case ($urandom_range(0, 9))
			0: s = 24'sh7FFFFF;
			1: s = 24'sh800000;
			2, 3: s = dfiir_pkg::SAMPLE_W'($urandom);
			default: s = dfiir_pkg::SAMPLE_W'(int'($urandom_range(0, (1 << 19) - 1)) - (1 << 18));
		endcase
		return s;
	endfunction

	task automatic send_item(
		input logic [dfiir_pkg::OP_W-1:0]            op,
		input logic [dfiir_pkg::TAP_IDX_W-1:0]       idx,
		input logic signed [dfiir_pkg::COEF_W-1:0]   coef,
		input logic signed [dfiir_pkg::SAMPLE_W-1:0] smp,
		input bit                                    known,
		input logic signed [dfiir_pkg::SAMPLE_W-1:0] known_y,
		input logic                                  known_clip
	);
		bit                                    produced;
		logic signed [dfiir_pkg::SAMPLE_W-1:0] y;
		logic                                  clip;
		filtered_t                             res;
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		tap_index <= idx;
		coefficient_value <= coef;
		sample_in <= smp;
		do @(posedge clk); while (in_stall);
		compute_iir_output(op, idx, coef, smp, produced, y, clip);
		if (produced) begin
			res.sample = known ? known_y : y;
			res.clip = known ? known_clip : clip;
			expected_outputs.push_back(res);
		end
		if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13) - 1) @(negedge clk);
		end
	endtask

	task automatic drain_outputs();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_outputs.size() != 0) @(negedge clk);
		// extra idle time after the last expected output
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_tap_counts(input logic [dfiir_pkg::TAPS_W-1:0] n_num,
		input logic [dfiir_pkg::TAPS_W-1:0] n_den);
		drain_outputs();
		cfg_we <= 1'b1;
		cfg_index <= dfiir_pkg::REG_NUM_TAPS;
		cfg_data <= n_num;
		@(negedge clk);
		cfg_index <= dfiir_pkg::REG_DEN_TAPS;
		cfg_data <= n_den;
		@(negedge clk);
		cfg_we <= 1'b0;
		num_taps = n_num;
		den_taps = n_den;
	endtask

	task automatic random_item(input int num_span, input int den_span);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 88) begin
			send_item(dfiir_pkg::OP_FILTER, dfiir_pkg::TAP_IDX_W'($urandom), $urandom,
				random_sample(), 1'b0, '0, 1'b0);
		end else if (pick < 94) begin
			send_item(OP_UNUSED, dfiir_pkg::TAP_IDX_W'($urandom), $urandom,
				dfiir_pkg::SAMPLE_W'($urandom), 1'b0, '0, 1'b0);
		end else if (pick < 97) begin
			send_item(dfiir_pkg::OP_WR_NUM, dfiir_pkg::TAP_IDX_W'($urandom),
				random_coef(num_span), dfiir_pkg::SAMPLE_W'($urandom), 1'b0, '0, 1'b0);
		end else begin
			send_item(dfiir_pkg::OP_WR_DEN, dfiir_pkg::TAP_IDX_W'($urandom),
				random_coef(den_span), dfiir_pkg::SAMPLE_W'($urandom), 1'b0, '0, 1'b0);
		end
	endtask

	initial begin
		logic [dfiir_pkg::TAPS_W-1:0] n_num;
		logic [dfiir_pkg::TAPS_W-1:0] n_den;
		bit                           quiet;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = dfiir_pkg::OP_FILTER;
		tap_index = '0;
		coefficient_value = '0;
		sample_in = '0;
		hold_request = 1'b0;
		in_gap_pct = 0;
		out_stall_pct = 0;
		for (int i = 0; i < dfiir_pkg::MAX_TAP_COUNT; i++) begin
			num_coef[i] = '0;
			den_coef[i] = '0;
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
		num_coef[0] = dfiir_pkg::COEF_ONE;
		den_coef[0] = dfiir_pkg::COEF_ONE;
		ring_pos = '0;
		num_taps = 5'd1;
		den_taps = 5'd1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		in_gap_pct = 20;
		out_stall_pct = 5;
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].coef,
				directed_rows[i].smp, directed_rows[i].known, directed_rows[i].y,
				directed_rows[i].clip);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin n_num = 5'd16; n_den = 5'd16; end
				1: begin n_num = 5'd0;  n_den = 5'd0;  end
				2: begin n_num = 5'd31; n_den = 5'd17; end
				3: begin n_num = 5'd1;  n_den = 5'd16; end
				4: begin n_num = 5'd16; n_den = 5'd1;  end
				default: begin
					n_num = dfiir_pkg::TAPS_W'($urandom);
					n_den = dfiir_pkg::TAPS_W'($urandom);
				end
			endcase
			quiet = (phase >= NUM_PHASES - 2);
			case ($urandom_range(0, 2))
				0: begin in_gap_pct = 0;  out_stall_pct = 0; end
				1: begin in_gap_pct = 15; out_stall_pct = 3; end
				default: begin in_gap_pct = 40; out_stall_pct = 8; end
			endcase
			if (quiet) begin
				in_gap_pct = 0;
				out_stall_pct = 0;
			end
			write_tap_counts(n_num, n_den);
			for (int k = 0; k < dfiir_pkg::MAX_TAP_COUNT; k++) begin
				send_item(dfiir_pkg::OP_WR_NUM, dfiir_pkg::TAP_IDX_W'(k), random_coef(25),
					dfiir_pkg::SAMPLE_W'($urandom), 1'b0, '0, 1'b0);
				send_item(dfiir_pkg::OP_WR_DEN, dfiir_pkg::TAP_IDX_W'(k), random_coef(23),
					dfiir_pkg::SAMPLE_W'($urandom), 1'b0, '0, 1'b0);
			end
			if (phase == 2)
				hold_request = 1'b1;
			repeat (PHASE_SAMPLES) random_item(25, 23);
		end

		drain_outputs();
		if (mismatch_count == 0 && expected_outputs.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// output side back-pressure, plus one long hold to fill the block
	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_done = 1'b1;
			end else if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_outputs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected output transfer: sample %0d sat %0b", sample_out, saturated);
			end else begin
				oldest = expected_outputs.pop_front();
				if (sample_out !== oldest.sample || saturated !== oldest.clip) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("output error: expected sample %0d sat %0b, got sample %0d sat %0b",
							oldest.sample, oldest.clip, sample_out, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
